>>> hw/rtl/btc_pkg.sv
// Shared constants, codes and controller/datapath command types for the closure block.
package btc_pkg;

    // Matrix size and field widths
    localparam int MAX_NODES = 16;
    localparam int ROW_W     = MAX_NODES;
    localparam int IDX_W     = $clog2(MAX_NODES);
    localparam int CFG_W     = 5;
    localparam int NC_W      = $clog2(MAX_NODES + 1);
    localparam int LOG_N     = $clog2(MAX_NODES);
    localparam int PASS_W    = $clog2(LOG_N + 1);
    localparam int FUNC_W    = 2;
    localparam int NODES_RST = 16;

    // Stream beat layout
    localparam int S_DATA_W = 24;
    localparam int M_BITS   = 2 * ROW_W + 1;
    localparam int M_DATA_W = 40;

    // Function codes of an input beat
    localparam logic [FUNC_W-1:0] FN_WRITE = 2'd0;
    localparam logic [FUNC_W-1:0] FN_CALC  = 2'd1;
    localparam logic [FUNC_W-1:0] FN_READ  = 2'd2;

    // Controller to datapath command
    typedef struct packed {
        logic             wr;
        logic             rd;
        logic             init;
        logic             sq_row;
        logic             copy;
        logic             red_row;
        logic             last;
        logic [IDX_W-1:0] row;
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic [NC_W-1:0]   nodes;
        logic [PASS_W-1:0] passes;
    } t_stat;

endpackage

>>> hw/rtl/btc_ctrl.sv
// Sequencer for row writes, reads and the closure/reduction compute run.
module btc_ctrl (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_s_tvalid,
    input  logic [btc_pkg::FUNC_W-1:0]   i_func,
    input  logic                         i_m_tready,
    input  btc_pkg::t_stat               i_stat,
    output logic                         o_s_tready,
    output logic                         o_m_tvalid,
    output logic                         o_cfg_ready,
    output btc_pkg::t_cmd                o_cmd
);
    import btc_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_INIT = 3'd1;
    localparam logic [2:0] ST_SQ   = 3'd2;
    localparam logic [2:0] ST_COPY = 3'd3;
    localparam logic [2:0] ST_RED  = 3'd4;

    logic [2:0]        r_state, n_state;
    logic [IDX_W-1:0]  r_row, n_row;
    logic [PASS_W-1:0] r_pass, n_pass;
    logic              r_out_valid, n_out_valid;
    logic              w_idle;
    logic              w_acc;
    logic              w_last_row;

    assign w_idle      = (r_state == ST_IDLE);
    assign o_s_tready  = w_idle && (!r_out_valid || i_m_tready);
    assign o_cfg_ready = w_idle;
    assign o_m_tvalid  = r_out_valid;
    assign w_acc       = i_s_tvalid && o_s_tready;
    assign w_last_row  = (NC_W'(r_row) == (i_stat.nodes - NC_W'(1)));

    // Next state and command decode
    always_comb begin
        n_state     = r_state;
        n_row       = r_row;
        n_pass      = r_pass;
        o_cmd       = '0;
        o_cmd.row   = r_row;
        o_cmd.last  = w_last_row;
        case (r_state)
            ST_IDLE: begin
                if (w_acc) begin
                    case (i_func)
                        FN_WRITE: o_cmd.wr = 1'b1;
                        FN_READ:  o_cmd.rd = 1'b1;
                        FN_CALC:  n_state  = ST_INIT;
                        default:  ;
                    endcase
                end
            end
            ST_INIT: begin
                o_cmd.init = 1'b1;
                n_row      = '0;
                n_pass     = '0;
                n_state    = (i_stat.passes == '0) ? ST_RED : ST_SQ;
            end
            ST_SQ: begin
                o_cmd.sq_row = 1'b1;
                if (w_last_row) begin
                    n_row   = '0;
                    n_state = ST_COPY;
                end else begin
                    n_row = r_row + IDX_W'(1);
                end
            end
            ST_COPY: begin
                o_cmd.copy = 1'b1;
                n_pass     = r_pass + PASS_W'(1);
                n_state    = ((r_pass + PASS_W'(1)) == i_stat.passes) ? ST_RED : ST_SQ;
            end
            ST_RED: begin
                o_cmd.red_row = 1'b1;
                if (w_last_row) begin
                    n_row   = '0;
                    n_state = ST_IDLE;
                end else begin
                    n_row = r_row + IDX_W'(1);
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Result beat valid: set by a read, dropped when taken
    always_comb begin
        if (o_cmd.rd) begin
            n_out_valid = 1'b1;
        end else if (i_m_tready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_row       <= '0;
            r_pass      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_row       <= n_row;
            r_pass      <= n_pass;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

>>> hw/rtl/btc_dp.sv
// Matrix storage and row-at-a-time squaring, reduction and cycle walk datapath.
module btc_dp (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  btc_pkg::t_cmd                i_cmd,
    input  logic [btc_pkg::IDX_W-1:0]    i_row_index,
    input  logic [btc_pkg::ROW_W-1:0]    i_row_bits,
    input  logic                         i_cfg_we,
    input  logic [btc_pkg::CFG_W-1:0]    i_cfg_data,
    output btc_pkg::t_stat               o_stat,
    output logic [btc_pkg::M_BITS-1:0]   o_result
);
    import btc_pkg::*;

    logic [CFG_W-1:0]  r_cfg;
    logic [ROW_W-1:0]  r_adj [MAX_NODES];
    logic [ROW_W-1:0]  r_anc [MAX_NODES];
    logic [ROW_W-1:0]  r_tmp [MAX_NODES];
    logic [ROW_W-1:0]  r_red [MAX_NODES];
    logic              r_cycle;
    logic [ROW_W-1:0]  r_walk;
    logic [M_BITS-1:0] r_result;

    logic [NC_W-1:0]   w_nodes;
    logic [PASS_W-1:0] w_passes;
    logic [ROW_W-1:0]  w_m     [MAX_NODES];
    logic [ROW_W-1:0]  w_init  [MAX_NODES];
    logic [ROW_W-1:0]  w_sq;
    logic [ROW_W-1:0]  w_two;
    logic [ROW_W-1:0]  w_bad;
    logic [ROW_W-1:0]  w_red;
    logic [ROW_W-1:0]  w_walk;
    logic [ROW_W-1:0]  w_cur_anc;
    logic [ROW_W-1:0]  w_cur_m;

    // Clamp node count to 1..MAX_NODES
    always_comb begin
        if (r_cfg == '0) begin
            w_nodes = NC_W'(1);
        end else if (int'(r_cfg) > MAX_NODES) begin
            w_nodes = NC_W'(MAX_NODES);
        end else begin
            w_nodes = NC_W'(r_cfg);
        end
    end

    // Squaring passes: number of p with 2^p < n
    always_comb begin
        w_passes = '0;
        for (int p = 0; p < LOG_N; p++) begin
            if ((1 << p) < int'(w_nodes)) begin
                w_passes = w_passes + PASS_W'(1);
            end
        end
    end

    assign o_stat.nodes  = w_nodes;
    assign o_stat.passes = w_passes;

    // Active adjacency: rows and bits beyond the node count masked off
    always_comb begin
        for (int i = 0; i < MAX_NODES; i++) begin
            for (int j = 0; j < ROW_W; j++) begin
                w_m[i][j] = r_adj[i][j] && (i < int'(w_nodes)) && (j < int'(w_nodes));
            end
        end
    end

    // Initial reachability: transpose of the active adjacency plus the diagonal
    always_comb begin
        for (int i = 0; i < MAX_NODES; i++) begin
            for (int j = 0; j < ROW_W; j++) begin
                w_init[i][j] = (i < int'(w_nodes)) && (w_m[j][i] || (i == j));
            end
        end
    end

    assign w_cur_anc = r_anc[i_cmd.row];
    assign w_cur_m   = w_m[i_cmd.row];

    // One squared row: OR of the rows this row already reaches
    always_comb begin
        w_sq = '0;
        for (int j = 0; j < MAX_NODES; j++) begin
            if (w_cur_anc[j]) begin
                w_sq = w_sq | r_anc[j];
            end
        end
    end

    // One reduced row: drop edges to nodes that are reached from a two-step successor
    always_comb begin
        w_two = '0;
        for (int k = 0; k < MAX_NODES; k++) begin
            if (w_cur_m[k]) begin
                w_two = w_two | w_m[k];
            end
        end
        for (int j = 0; j < ROW_W; j++) begin
            w_bad[j] = |(r_anc[j] & w_two);
        end
        w_red = w_cur_m & ~w_bad;
    end

    // One step of the walk from node 0
    always_comb begin
        for (int i = 0; i < ROW_W; i++) begin
            w_walk[i] = |(w_m[i] & r_walk);
        end
    end

    // Stored matrices, node count and cycle flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg   <= CFG_W'(NODES_RST);
            r_cycle <= 1'b0;
            for (int i = 0; i < MAX_NODES; i++) begin
                r_adj[i] <= '0;
                r_anc[i] <= '0;
                r_red[i] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                r_cfg <= i_cfg_data;
            end
            if (i_cmd.wr) begin
                r_adj[i_row_index] <= i_row_bits;
            end
            if (i_cmd.init) begin
                for (int i = 0; i < MAX_NODES; i++) begin
                    r_anc[i] <= w_init[i];
                    r_red[i] <= '0;
                end
            end
            if (i_cmd.copy) begin
                for (int i = 0; i < MAX_NODES; i++) begin
                    if (i < int'(w_nodes)) begin
                        r_anc[i] <= r_tmp[i];
                    end
                end
            end
            if (i_cmd.red_row) begin
                r_red[i_cmd.row] <= w_red;
                if (i_cmd.last) begin
                    r_cycle <= |w_walk;
                end
            end
        end
    end

    // Scratch rows, walk vector and result payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.sq_row) begin
            r_tmp[i_cmd.row] <= w_sq;
        end
        if (i_cmd.init) begin
            r_walk <= ROW_W'(1);
        end else if (i_cmd.red_row) begin
            r_walk <= w_walk;
        end
        if (i_cmd.rd) begin
            r_result <= {r_cycle, r_red[i_row_index], r_anc[i_row_index]};
        end
    end

    assign o_result = r_result;

endmodule

>>> hw/rtl/boolean_transitive_closure_reduction_top.sv
// Top level of the boolean transitive closure and reduction block.
//
//  channel  | direction | signals                          | beat contents
//  ---------+-----------+----------------------------------+----------------------------------
//  s        | in        | i_s_tvalid o_s_tready i_s_tdata  | func, row_index, row_bits
//  m        | out       | o_m_tvalid i_m_tready o_m_tdata  | reach_row, reduced_row, cycle_found
//  cfg      | in        | i_cfg_valid o_cfg_ready i_cfg_data | node_count
//
// Row writes and reads complete as their beat is taken; a read result shows up on m the next cycle.
// A compute beat runs init, then P passes (n nodes in use, P = ceil(log2 n)) that each
// square one matrix row per cycle in the shared squaring unit and copy, then a reduction.
// Synchronous active-low reset clears adjacency, reach, reduced rows, cycle flag; n = 16.
// While m is stalled with a result waiting, s is held off; cfg stays open whenever idle.
module boolean_transitive_closure_reduction_top
    import btc_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_tvalid,
    output logic                 o_s_tready,
    input  logic [S_DATA_W-1:0]  i_s_tdata,   // [1:0] func, [5:2] row_index, [21:6] row_bits
    output logic                 o_m_tvalid,
    input  logic                 i_m_tready,
    output logic [M_DATA_W-1:0]  o_m_tdata,   // [15:0] reach_row, [31:16] reduced_row,
                                              // [32] cycle_found
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    t_cmd              w_cmd;
    t_stat             w_stat;
    logic [M_BITS-1:0] w_result;
    logic [FUNC_W-1:0] w_func;

    assign w_func = i_s_tdata[FUNC_W-1:0];

    btc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .i_func      (w_func),
        .i_m_tready  (i_m_tready),
        .i_stat      (w_stat),
        .o_s_tready  (o_s_tready),
        .o_m_tvalid  (o_m_tvalid),
        .o_cfg_ready (o_cfg_ready),
        .o_cmd       (w_cmd)
    );

    btc_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_row_index (i_s_tdata[FUNC_W +: IDX_W]),
        .i_row_bits  (i_s_tdata[FUNC_W + IDX_W +: ROW_W]),
        .i_cfg_we    (i_cfg_valid && o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .o_stat      (w_stat),
        .o_result    (w_result)
    );

    assign o_m_tdata = {{(M_DATA_W - M_BITS){1'b0}}, w_result};

    // A read beat taken produces a result beat on the next cycle
    a_read_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready && (w_func == FN_READ)) |=> o_m_tvalid)
        else $error("read beat gave no result beat");

    // A compute beat taken closes the input until the run ends
    a_calc_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready && (w_func == FN_CALC)) |=> (!o_s_tready && !o_cfg_ready))
        else $error("input open right after compute beat");

    // Input is only open when configuration is open too
    a_idle_cfg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_s_tready |-> o_cfg_ready)
        else $error("input ready outside idle");

    // Writes and computes never produce a result beat
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready && (w_func != FN_READ) && !o_m_tvalid) |=> !o_m_tvalid)
        else $error("result beat without read");

endmodule
